FILE: rtl/utf8_utf16le_text_decoder_unit_macros.svh
// Assertion macros for the text decoder checker.
// Pulled in by the checker file; no other dependencies.
`ifndef UTF8_UTF16LE_TEXT_DECODER_UNIT_MACROS_SVH
`define UTF8_UTF16LE_TEXT_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define U8U16_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u8u16 check failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define U8U16_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("u8u16 check failed: next-cycle implication");

`endif

FILE: rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 / UTF-16LE text decoder.
// No dependencies; used by the controller, datapath, top level and checker.
package u8u16_pkg;

	localparam int LINE_BITS   = 20;
	localparam int COLUMN_BITS = 16;

	// replacement character '_'
	localparam logic [15:0] CODE_SUBST = 16'h005F;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} byte_beat_t;

	typedef struct packed {
		logic [15:0]            code_unit;
		logic [LINE_BITS-1:0]   line_number;
		logic [COLUMN_BITS-1:0] column_number;
		logic [2:0]             byte_count;
		logic                   replaced;
		logic                   truncated;
		logic                   encoding_used;
		logic                   last_of_run;
		logic                   end_of_stream;
	} unit_beat_t;

	typedef enum logic [2:0] {
		ST_HEAD,
		ST_DETECT,
		ST_REPLAY,
		ST_FLUSH,
		ST_RUN
	} dec_state_t;

	// controller -> datapath
	typedef struct packed {
		logic hold;       // store header byte
		logic detect;     // pick encoding and drop count
		logic feed_head;  // decode next held byte
		logic feed_live;  // decode the incoming byte
		logic flush;      // push last pending result out
		logic clear;      // rearm for a new stream
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic head_last;    // the fourth header byte is next
		logic replay_last;  // last held byte is being replayed
		logic out_free;     // output register can take a result
		logic end_seen;     // header phase ended with stream end
	} dp_stat_t;

endpackage

FILE: rtl/u8u16_ctrl.sv
// Sequencer for the text decoder: header capture, detection, replay, flush, run.
// Depends on u8u16_pkg; drives the datapath through dp_cmd_t.
module u8u16_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic                byte_end,
	output logic                byte_stall,
	input  u8u16_pkg::dp_stat_t stat,
	output u8u16_pkg::dp_cmd_t  cmd
);
	import u8u16_pkg::*;

	dec_state_t state_q;
	dec_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_HEAD: begin
				if (byte_valid && (stat.head_last || byte_end)) begin
					state_d = ST_DETECT;
				end
			end
			ST_DETECT: begin
				state_d = ST_REPLAY;
			end
			ST_REPLAY: begin
				if (stat.out_free && stat.replay_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					state_d = stat.end_seen ? ST_HEAD : ST_RUN;
				end
			end
			ST_RUN: begin
				if (byte_valid && stat.out_free && byte_end) begin
					state_d = ST_HEAD;
				end
			end
			default: begin
				state_d = ST_HEAD;
			end
		endcase
	end

	always_comb begin
		byte_stall = 1'b1;
		cmd        = '0;
		case (state_q)
			ST_HEAD: begin
				byte_stall = 1'b0;
				cmd.hold   = byte_valid;
			end
			ST_DETECT: begin
				cmd.detect = 1'b1;
			end
			ST_REPLAY: begin
				cmd.feed_head = stat.out_free;
			end
			ST_FLUSH: begin
				cmd.flush = stat.out_free;
				cmd.clear = stat.out_free && stat.end_seen;
			end
			ST_RUN: begin
				byte_stall    = !stat.out_free;
				cmd.feed_live = byte_valid && stat.out_free;
				cmd.clear     = byte_valid && stat.out_free && byte_end;
			end
			default: begin
				byte_stall = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/u8u16_dpath.sv
// Datapath of the text decoder: header store, detection, one-byte decoder,
// line/column counters, pending result and output register.
// Depends on u8u16_pkg; commanded by u8u16_ctrl.
module u8u16_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  u8u16_pkg::byte_beat_t byte_data,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  unit_stall,
	output logic                  unit_valid,
	output u8u16_pkg::unit_beat_t unit_data,
	input  u8u16_pkg::dp_cmd_t    cmd,
	output u8u16_pkg::dp_stat_t   stat
);
	import u8u16_pkg::*;

	localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
	localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;
	localparam logic [15:0] CODE_NEWLINE = 16'h000A;
	localparam logic        ENC_UTF8     = 1'b0;
	localparam logic        ENC_UTF16LE  = 1'b1;
	localparam logic [7:0]  BOM16_B0 = 8'hFF;
	localparam logic [7:0]  BOM16_B1 = 8'hFE;
	localparam logic [7:0]  BOM8_B0  = 8'hEF;
	localparam logic [7:0]  BOM8_B1  = 8'hBB;
	localparam logic [7:0]  BOM8_B2  = 8'hBF;
	localparam logic [7:0]  MASK_L2  = 8'hE0;
	localparam logic [7:0]  LEAD_L2  = 8'hC0;
	localparam logic [7:0]  MASK_L3  = 8'hF0;
	localparam logic [7:0]  LEAD_L3  = 8'hE0;
	localparam logic [7:0]  MASK_L4  = 8'hF8;
	localparam logic [7:0]  LEAD_L4  = 8'hF0;
	localparam logic [7:0]  MASK_L5  = 8'hFC;
	localparam logic [7:0]  LEAD_L5  = 8'hF8;
	localparam logic [7:0]  MASK_L6  = 8'hFE;
	localparam logic [7:0]  LEAD_L6  = 8'hFC;
	localparam logic [7:0]  PAY_L2   = 8'h1F;
	localparam logic [7:0]  PAY_L3   = 8'h0F;

	logic [7:0]             head_q [4];
	logic [2:0]             hcnt_q;
	logic                   end_q;
	logic                   dflt_q;
	logic                   enc_q;
	logic [1:0]             rp_q;
	logic [15:0]            part_q;
	logic [2:0]             rem_q;
	logic [2:0]             len_q;
	logic                   skip_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic                   nl_q;
	logic                   pend_valid_q;
	logic                   out_valid_q;
	unit_beat_t             pend_q;
	unit_beat_t             out_q;

	logic                   det_enc;
	logic [1:0]             det_drop;
	logic                   replay_last;
	logic                   out_free;
	logic                   feed;
	logic [7:0]             fb;
	logic                   ffinal;
	logic                   f_emit;
	logic [15:0]            f_code;
	logic [2:0]             f_cnt;
	logic                   f_repl;
	logic                   f_trunc;
	logic [15:0]            n_part;
	logic [2:0]             n_rem;
	logic [2:0]             n_len;
	logic                   n_skip;
	logic [LINE_BITS-1:0]   e_line;
	logic [COLUMN_BITS-1:0] e_col;
	logic [COLUMN_BITS-1:0] n_col;
	unit_beat_t             res;
	unit_beat_t             pend_fin;

	// encoding detection over the four held bytes
	always_comb begin
		det_enc  = dflt_q;
		det_drop = 2'd0;
		if (hcnt_q == 3'd4) begin
			if (head_q[0] == BOM16_B0 && head_q[1] == BOM16_B1) begin
				det_enc  = ENC_UTF16LE;
				det_drop = 2'd2;
			end else if (head_q[0] == BOM8_B0 && head_q[1] == BOM8_B1 &&
			             head_q[2] == BOM8_B2) begin
				det_enc  = ENC_UTF8;
				det_drop = 2'd3;
			end else if (head_q[1] == 8'h00 && head_q[3] == 8'h00 &&
			             head_q[0] != 8'h00 && head_q[2] != 8'h00) begin
				det_enc = ENC_UTF16LE;
			end
		end
	end

	assign replay_last = (({1'b0, rp_q} + 3'd1) == hcnt_q);
	assign out_free    = !out_valid_q || !unit_stall;
	assign feed        = cmd.feed_head || cmd.feed_live;
	assign fb          = cmd.feed_live ? byte_data.data_byte : head_q[rp_q];
	assign ffinal      = cmd.feed_live ? byte_data.stream_end : (end_q && replay_last);

	// one-byte decode step
	always_comb begin
		f_emit  = 1'b0;
		f_code  = CODE_SUBST;
		f_cnt   = 3'd1;
		f_repl  = 1'b0;
		f_trunc = 1'b0;
		n_part  = part_q;
		n_rem   = rem_q;
		n_len   = len_q;
		n_skip  = skip_q;
		if (enc_q == ENC_UTF16LE) begin
			if (rem_q == 3'd0) begin
				n_len  = 3'd2;
				n_rem  = 3'd1;
				n_skip = 1'b0;
				n_part = {8'h00, fb};
			end else begin
				n_rem  = 3'd0;
				f_emit = 1'b1;
				f_code = part_q | {fb, 8'h00};
				f_cnt  = 3'd2;
			end
		end else if (rem_q == 3'd0) begin
			if (!fb[7]) begin
				f_emit = 1'b1;
				f_code = {8'h00, fb};
			end else if ((fb & MASK_L2) == LEAD_L2) begin
				n_len = 3'd2; n_rem = 3'd1; n_skip = 1'b0; n_part = {8'h00, fb & PAY_L2};
			end else if ((fb & MASK_L3) == LEAD_L3) begin
				n_len = 3'd3; n_rem = 3'd2; n_skip = 1'b0; n_part = {8'h00, fb & PAY_L3};
			end else if ((fb & MASK_L4) == LEAD_L4) begin
				n_len = 3'd4; n_rem = 3'd3; n_skip = 1'b1; n_part = 16'h0000;
			end else if ((fb & MASK_L5) == LEAD_L5) begin
				n_len = 3'd5; n_rem = 3'd4; n_skip = 1'b1; n_part = 16'h0000;
			end else if ((fb & MASK_L6) == LEAD_L6) begin
				n_len = 3'd6; n_rem = 3'd5; n_skip = 1'b1; n_part = 16'h0000;
			end else begin
				// stray continuation byte or FE/FF lead
				f_emit = 1'b1;
				f_repl = 1'b1;
			end
		end else begin
			if (!skip_q) begin
				n_part = {part_q[9:0], fb[5:0]};
			end
			n_rem = rem_q - 3'd1;
			if (n_rem == 3'd0) begin
				f_emit = 1'b1;
				f_cnt  = len_q;
				f_repl = skip_q;
				f_code = skip_q ? CODE_SUBST : n_part;
				n_skip = 1'b0;
			end
		end
		// stream ends inside a sequence
		if (ffinal && n_rem != 3'd0) begin
			f_emit  = 1'b1;
			f_code  = CODE_SUBST;
			f_cnt   = n_len - n_rem;
			f_repl  = 1'b1;
			f_trunc = 1'b1;
			n_rem   = 3'd0;
			n_skip  = 1'b0;
		end
	end

	// position of the emitted character
	always_comb begin
		e_line = line_q;
		e_col  = col_q;
		if (nl_q) begin
			if (line_q != LINE_MAX) begin
				e_line = line_q + 1'b1;
			end
			e_col = '0;
		end
		n_col = (e_col != COLUMN_MAX) ? e_col + 1'b1 : e_col;
	end

	always_comb begin
		res.code_unit     = f_code;
		res.line_number   = e_line;
		res.column_number = e_col;
		res.byte_count    = f_cnt;
		res.replaced      = f_repl;
		res.truncated     = f_trunc;
		res.encoding_used = enc_q;
		res.last_of_run   = cmd.feed_live;
		res.end_of_stream = cmd.feed_live && byte_data.stream_end;
		pend_fin               = pend_q;
		pend_fin.last_of_run   = 1'b1;
		pend_fin.end_of_stream = end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q       <= '0;
			end_q        <= 1'b0;
			dflt_q       <= ENC_UTF8;
			enc_q        <= ENC_UTF8;
			rp_q         <= '0;
			part_q       <= '0;
			rem_q        <= '0;
			len_q        <= '0;
			skip_q       <= 1'b0;
			line_q       <= '0;
			col_q        <= '0;
			nl_q         <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				dflt_q <= cfg_wdata;
			end
			if (cmd.hold) begin
				hcnt_q <= hcnt_q + 3'd1;
				end_q  <= byte_data.stream_end;
			end
			if (cmd.detect) begin
				enc_q <= det_enc;
				rp_q  <= det_drop;
			end
			if (cmd.feed_head) begin
				rp_q <= rp_q + 2'd1;
			end
			if (feed) begin
				part_q <= n_part;
				rem_q  <= n_rem;
				len_q  <= n_len;
				skip_q <= n_skip;
				if (f_emit) begin
					line_q <= e_line;
					col_q  <= n_col;
					nl_q   <= (f_code == CODE_NEWLINE);
				end
			end
			if (cmd.flush) begin
				hcnt_q <= '0;
			end
			if (cmd.clear) begin
				hcnt_q <= '0;
				end_q  <= 1'b0;
				enc_q  <= ENC_UTF8;
				part_q <= '0;
				rem_q  <= '0;
				len_q  <= '0;
				skip_q <= 1'b0;
				line_q <= '0;
				col_q  <= '0;
				nl_q   <= 1'b0;
			end

			if (out_valid_q && !unit_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.feed_live && f_emit) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.feed_head && f_emit) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
			end
			if (cmd.flush && pend_valid_q) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			head_q[hcnt_q[1:0]] <= byte_data.data_byte;
		end
		if (cmd.feed_live && f_emit) begin
			out_q <= res;
		end
		if (cmd.feed_head && f_emit) begin
			pend_q <= res;
			if (pend_valid_q) begin
				out_q <= pend_q;
			end
		end
		if (cmd.flush && pend_valid_q) begin
			out_q <= pend_fin;
		end
	end

	assign unit_valid       = out_valid_q;
	assign unit_data        = out_q;
	assign stat.head_last   = (hcnt_q == 3'd3);
	assign stat.replay_last = replay_last;
	assign stat.out_free    = out_free;
	assign stat.end_seen    = end_q;

endmodule

FILE: rtl/utf8_utf16le_text_decoder_unit.sv
// Top level of the UTF-8 / UTF-16LE text decoder.
// Depends on u8u16_pkg, u8u16_ctrl and u8u16_dpath.
//
// Takes a text stream one byte per beat and delivers 16-bit code units, each
// with a saturating zero-based line and column, the byte count it consumed
// and replace/truncate flags. The first four bytes of every stream (fewer if
// stream_end comes earlier) are held to pick the encoding: an FF FE mark
// means UTF-16LE, EF BB BF means UTF-8, a nonzero/zero/nonzero/zero pattern
// means UTF-16LE, anything else falls back to default_encoding. A mark is
// dropped and the remaining held bytes are replayed through the decoder.
// Timing: header bytes are taken one per cycle; after the header beat the
// input stalls while the encoding is detected, the held bytes (up to four)
// are replayed and the last replayed result is pushed out. From then on one
// byte is taken per cycle, set by the single decode unit and the one-entry
// output register; a stalled output holds the input off. The beat carrying
// stream_end rearms the block for a new stream; default_encoding keeps its
// value. Write cfg_we only while no stream is in flight.
module utf8_utf16le_text_decoder_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  u8u16_pkg::byte_beat_t byte_data,
	output logic                  unit_valid,
	input  logic                  unit_stall,
	output u8u16_pkg::unit_beat_t unit_data
);
	import u8u16_pkg::*;

	dp_cmd_t  cmd;   // sequencer commands
	dp_stat_t stat;  // datapath status back to the sequencer

	// sequencer: header capture, detection, replay, flush, steady run
	u8u16_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_end   (byte_data.stream_end),
		.byte_stall (byte_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: header store, decoder, counters, pending and output beats
	u8u16_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_data  (byte_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.unit_stall (unit_stall),
		.unit_valid (unit_valid),
		.unit_data  (unit_data),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

FILE: rtl/u8u16_chk.sv
// Port-level checker for the text decoder, bound to the top level.
// Depends on u8u16_pkg and utf8_utf16le_text_decoder_unit_macros.svh.
`include "utf8_utf16le_text_decoder_unit_macros.svh"

module u8u16_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  unit_valid,
	input logic                  unit_stall,
	input u8u16_pkg::unit_beat_t unit_data
);
	import u8u16_pkg::*;

	// stalled output beat holds
	`U8U16_ASSERT_NXT(a_out_hold, clk, arst_n, unit_valid && unit_stall, unit_valid && $stable(unit_data))
	// a character always spans one to six bytes
	`U8U16_ASSERT_IMP(a_count_range, clk, arst_n, unit_valid, unit_data.byte_count != 3'd0 && unit_data.byte_count != 3'd7)
	// replaced characters carry the underscore
	`U8U16_ASSERT_IMP(a_repl_code, clk, arst_n, unit_valid && unit_data.replaced, unit_data.code_unit == CODE_SUBST)
	// a truncated sequence is always a replacement
	`U8U16_ASSERT_IMP(a_trunc_repl, clk, arst_n, unit_valid && unit_data.truncated, unit_data.replaced)
	// stream end only marks the last beat of a run
	`U8U16_ASSERT_IMP(a_eos_last, clk, arst_n, unit_valid && unit_data.end_of_stream, unit_data.last_of_run)

endmodule

bind utf8_utf16le_text_decoder_unit u8u16_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.unit_valid (unit_valid),
	.unit_stall (unit_stall),
	.unit_data  (unit_data)
);
